/* rtl/tldmc_pkg.sv */
package tldmc_pkg;

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned CNT_W  = 32;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      OUTCOME_L1_HIT = 2'd0,
      OUTCOME_L2_HIT = 2'd1,
      OUTCOME_MISS   = 2'd2
   } outcome_type;

   localparam cnt_type COUNT_STEP  = 32'd1;
   localparam cnt_type HIT1_NS     = 32'd1;
   localparam cnt_type HIT2_NS     = 32'd5;
   localparam cnt_type MISS_TENTHS = 32'd104;

   // Counters stick at all ones instead of wrapping.
   function automatic cnt_type sat_add(cnt_type a, cnt_type b);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
   endfunction

endpackage

/* rtl/tldmc_ifs.sv */
interface tldmc_req_if;
   import tldmc_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink (input valid, input address, output ready);
endinterface

interface tldmc_rsp_if;
   import tldmc_pkg::*;

   logic    valid;
   logic    ready;
   logic [1:0] outcome;
   cnt_type access_total;
   cnt_type miss_total;
   cnt_type first_level_hits;
   cnt_type second_level_hits;
   cnt_type first_level_latency_ns;
   cnt_type second_level_latency_ns;
   cnt_type miss_penalty_tenths;

   modport source (output valid, output outcome, output access_total, output miss_total,
      output first_level_hits, output second_level_hits, output first_level_latency_ns,
      output second_level_latency_ns, output miss_penalty_tenths, input ready);
   modport sink (input valid, input outcome, input access_total, input miss_total,
      input first_level_hits, input second_level_hits, input first_level_latency_ns,
      input second_level_latency_ns, input miss_penalty_tenths, output ready);
endinterface

/* rtl/tldmc_ram.sv */
module tldmc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tldmc_front.sv */
module tldmc_front #(
   parameter int unsigned ADDR_BITS   = 32,
   parameter int unsigned OFFSET_BITS = 6,
   parameter int unsigned I1_W        = 8,
   parameter int unsigned T1_W        = 18,
   parameter int unsigned I2_W        = 10,
   parameter int unsigned T2_W        = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   tldmc_req_if.sink                        req_ch,
   input  logic                             clearing,
   output logic                             pop_valid,
   input  logic                             pop_ready,
   output logic [I1_W+T1_W+I2_W+T2_W-1:0]   pop_entry
);
   import tldmc_pkg::*;

   localparam int unsigned E_W         = I1_W + T1_W + I2_W + T2_W;
   localparam int unsigned EXT_W       = ADDR_BITS + I1_W + I2_W + 1;
   localparam int unsigned QUEUE_DEPTH = 2;

   logic [EXT_W-1:0] blk_ext;
   logic [I1_W-1:0]  idx1;
   logic [T1_W-1:0]  tag1;
   logic [I2_W-1:0]  idx2;
   logic [T2_W-1:0]  tag2;
   logic             push;
   logic             pop;

   logic [E_W-1:0] queue_ff [QUEUE_DEPTH];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   // The block number is widened so that index and tag selects never run off its top;
   // bits beyond the used address read as zero.
   assign blk_ext = EXT_W'(req_ch.address[ADDR_BITS-1:0] >> OFFSET_BITS);
   assign idx1    = blk_ext[I1_W-1:0];
   assign tag1    = T1_W'(blk_ext >> I1_W);
   assign idx2    = blk_ext[I2_W-1:0];
   assign tag2    = T2_W'(blk_ext >> I2_W);

   assign req_ch.ready = !clearing && (count_ff != 2'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign pop_valid    = (count_ff != 2'd0);
   assign pop          = pop_valid && pop_ready;
   assign pop_entry    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= {idx1, tag1, idx2, tag2};
      end
   end

endmodule

/* rtl/tldmc_back.sv */
module tldmc_back #(
   parameter int unsigned I1_W = 8,
   parameter int unsigned T1_W = 18,
   parameter int unsigned I2_W = 10,
   parameter int unsigned T2_W = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   output logic                             clearing,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  logic [I1_W+T1_W+I2_W+T2_W-1:0]   pop_entry,
   tldmc_rsp_if.source                      rsp_ch
);
   import tldmc_pkg::*;

   localparam int unsigned E_W      = I1_W + T1_W + I2_W + T2_W;
   localparam int unsigned L1_DEPTH = 2 ** I1_W;
   localparam int unsigned L2_DEPTH = 2 ** I2_W;
   localparam int unsigned CLR_W    = (I1_W > I2_W) ? I1_W : I2_W;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [E_W-1:0]   cur_ff, cur_in;
   logic        rsp_valid_ff, rsp_valid_in;
   outcome_type outcome_ff, outcome_in;
   cnt_type     access_ff, access_in;
   cnt_type     miss_ff, miss_in;
   cnt_type     hit1_ff, hit1_in;
   cnt_type     hit2_ff, hit2_in;
   cnt_type     lat1_ff, lat1_in;
   cnt_type     lat2_ff, lat2_in;
   cnt_type     pen_ff, pen_in;

   logic [I1_W-1:0] cur_i1, rd_i1;
   logic [T1_W-1:0] cur_t1;
   logic [I2_W-1:0] cur_i2, rd_i2;
   logic [T2_W-1:0] cur_t2;
   logic            hit1, hit2;
   logic            pop;

   logic            l1_we;
   logic [I1_W-1:0] l1_waddr;
   logic [T1_W:0]   l1_wdata, l1_rdata;
   logic            l2_we;
   logic [I2_W-1:0] l2_waddr;
   logic [T2_W:0]   l2_wdata, l2_rdata;

   assign cur_t2 = cur_ff[T2_W-1:0];
   assign cur_i2 = cur_ff[T2_W +: I2_W];
   assign cur_t1 = cur_ff[T2_W+I2_W +: T1_W];
   assign cur_i1 = cur_ff[T2_W+I2_W+T1_W +: I1_W];
   assign rd_i2  = pop_entry[T2_W +: I2_W];
   assign rd_i1  = pop_entry[T2_W+I2_W+T1_W +: I1_W];

   // Each tag memory word is {valid, tag}.
   tldmc_ram #(.WIDTH(T1_W + 1), .DEPTH(L1_DEPTH)) u_l1_tags (
      .clock   (clock),
      .wr_en   (l1_we),
      .wr_addr (l1_waddr),
      .wr_data (l1_wdata),
      .rd_addr (rd_i1),
      .rd_data (l1_rdata)
   );

   tldmc_ram #(.WIDTH(T2_W + 1), .DEPTH(L2_DEPTH)) u_l2_tags (
      .clock   (clock),
      .wr_en   (l2_we),
      .wr_addr (l2_waddr),
      .wr_data (l2_wdata),
      .rd_addr (rd_i2),
      .rd_data (l2_rdata)
   );

   assign hit1 = l1_rdata[T1_W] && (l1_rdata[T1_W-1:0] == cur_t1);
   assign hit2 = l2_rdata[T2_W] && (l2_rdata[T2_W-1:0] == cur_t2);

   assign clearing  = (state_ff == ST_CLEAR);
   // A new lookup starts only when the result register is free by the time it finishes.
   assign pop_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      outcome_in   = outcome_ff;
      access_in    = access_ff;
      miss_in      = miss_ff;
      hit1_in      = hit1_ff;
      hit2_in      = hit2_ff;
      lat1_in      = lat1_ff;
      lat2_in      = lat2_ff;
      pen_in       = pen_ff;
      l1_we        = 1'b0;
      l1_waddr     = cur_i1;
      l1_wdata     = {1'b1, cur_t1};
      l2_we        = 1'b0;
      l2_waddr     = cur_i2;
      l2_wdata     = {1'b1, cur_t2};
      unique case (state_ff)
         ST_CLEAR: begin
            l1_we    = 1'b1;
            l1_waddr = clr_ff[I1_W-1:0];
            l1_wdata = '0;
            l2_we    = 1'b1;
            l2_waddr = clr_ff[I2_W-1:0];
            l2_wdata = '0;
            clr_in   = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               cur_in   = pop_entry;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            access_in    = sat_add(access_ff, COUNT_STEP);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            priority if (hit1) begin
               // The second level is refreshed even on a first-level hit.
               l2_we      = 1'b1;
               hit1_in    = sat_add(hit1_ff, COUNT_STEP);
               lat1_in    = sat_add(lat1_ff, HIT1_NS);
               outcome_in = OUTCOME_L1_HIT;
            end else if (hit2) begin
               l1_we      = 1'b1;
               hit2_in    = sat_add(hit2_ff, COUNT_STEP);
               lat2_in    = sat_add(lat2_ff, HIT2_NS);
               outcome_in = OUTCOME_L2_HIT;
            end else begin
               l1_we      = 1'b1;
               l2_we      = 1'b1;
               miss_in    = sat_add(miss_ff, COUNT_STEP);
               pen_in     = sat_add(pen_ff, MISS_TENTHS);
               outcome_in = OUTCOME_MISS;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         access_ff    <= '0;
         miss_ff      <= '0;
         hit1_ff      <= '0;
         hit2_ff      <= '0;
         lat1_ff      <= '0;
         lat2_ff      <= '0;
         pen_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         access_ff    <= access_in;
         miss_ff      <= miss_in;
         hit1_ff      <= hit1_in;
         hit2_ff      <= hit2_in;
         lat1_ff      <= lat1_in;
         lat2_ff      <= lat2_in;
         pen_ff       <= pen_in;
      end
      cur_ff     <= cur_in;
      outcome_ff <= outcome_in;
   end

   // The counters only move in a lookup, which starts after the held result is taken,
   // so they serve directly as the result payload.
   assign rsp_ch.valid                   = rsp_valid_ff;
   assign rsp_ch.outcome                 = outcome_ff;
   assign rsp_ch.access_total            = access_ff;
   assign rsp_ch.miss_total              = miss_ff;
   assign rsp_ch.first_level_hits        = hit1_ff;
   assign rsp_ch.second_level_hits       = hit2_ff;
   assign rsp_ch.first_level_latency_ns  = lat1_ff;
   assign rsp_ch.second_level_latency_ns = lat2_ff;
   assign rsp_ch.miss_penalty_tenths     = pen_ff;

endmodule

/* rtl/two_level_direct_mapped_cache_model_unit.sv */
// Two-level direct-mapped cache lookup unit.
// Requests arrive on req_ch (valid/ready) and carry one byte address each. Every
// request produces exactly one response on rsp_ch with the outcome (first-level hit,
// second-level hit or miss in both) and the running saturating counters after it.
// A front stage splits the address into index and tag for both levels and parks the
// request in a two-entry queue; the back stage reads both tag memories as it takes a
// request, then compares and updates tags and counters in the next cycle.
// A response becomes valid once the request has passed the front queue, the registered
// tag-memory read and the result register. A new request enters the back stage only
// after the last one's read-then-write sequence on each tag memory's single write port.
// After reset the tag memories are swept to invalid, one line of each per cycle, across
// 2**max(first index bits, second index bits) addresses (1024 at the default sizes);
// req_ch.ready stays low until the sweep is done.
// When the receiver holds rsp_ch.ready low the response is held stable, the back
// stage waits, and the front queue keeps accepting until its two entries are full.
module two_level_direct_mapped_cache_model_unit #(
   parameter int unsigned FIRST_LINES  = 256,
   parameter int unsigned SECOND_LINES = 1024,
   parameter int unsigned OFFSET_BITS  = 6,
   parameter int unsigned ADDR_BITS    = 32
) (
   input  logic         clock,
   input  logic         reset,
   tldmc_req_if.sink    req_ch,
   tldmc_rsp_if.source  rsp_ch
);
   import tldmc_pkg::*;

   // Index width is floor(log2(lines)); lines beyond the largest power of two go unused.
   localparam int unsigned I1_W   = $clog2(FIRST_LINES + 1) - 1;
   localparam int unsigned I2_W   = $clog2(SECOND_LINES + 1) - 1;
   localparam int          T1_RAW = int'(ADDR_BITS) - int'(OFFSET_BITS) - int'(I1_W);
   localparam int          T2_RAW = int'(ADDR_BITS) - int'(OFFSET_BITS) - int'(I2_W);
   localparam int unsigned T1_W   = (T1_RAW < 1) ? 1 : T1_RAW;
   localparam int unsigned T2_W   = (T2_RAW < 1) ? 1 : T2_RAW;
   localparam int unsigned E_W    = I1_W + T1_W + I2_W + T2_W;

   logic           clearing;
   logic           pop_valid;
   logic           pop_ready;
   logic [E_W-1:0] pop_entry;

   tldmc_front #(
      .ADDR_BITS   (ADDR_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .I1_W        (I1_W),
      .T1_W        (T1_W),
      .I2_W        (I2_W),
      .T2_W        (T2_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .clearing  (clearing),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry)
   );

   tldmc_back #(
      .I1_W (I1_W),
      .T1_W (T1_W),
      .I2_W (I2_W),
      .T2_W (T2_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_ch    (rsp_ch)
   );

endmodule
